>>> design/e2q_pkg.sv
package e2q_pkg;

  localparam int ANGLE_WIDTH = 16;
  localparam int TRIG_STAGES = 16;

  localparam int FIELD_W = 16;
  localparam int ANGLE_BITS = (ANGLE_WIDTH < FIELD_W) ? ANGLE_WIDTH : FIELD_W;
  localparam int ANGLE_SHIFT = 17;
  localparam int TABLE_LEN = 24;
  localparam int CORDIC_N = (TRIG_STAGES < TABLE_LEN) ? TRIG_STAGES : TABLE_LEN;
  // load register, one register per iteration, sign-fix register
  localparam int CORDIC_LAT = CORDIC_N + 2;

  localparam int WIDE_W = FIELD_W + ANGLE_SHIFT + 1;  // angle moved to Q30
  localparam int Z_W = 33;
  localparam int X_W = 33;
  localparam int P1_W = 2 * X_W;
  localparam int TR_W = P1_W - 30;
  localparam int P3_W = TR_W + X_W;
  localparam int SUM_W = P3_W + 1;
  localparam int Q_W = 16;

  localparam logic signed [WIDE_W-1:0] PI_Q30 = WIDE_W'(64'sd3373259426);
  localparam logic signed [WIDE_W-1:0] HALF_PI_Q30 = WIDE_W'(64'sd1686629713);
  localparam logic signed [X_W-1:0] GAIN_Q30 = X_W'(64'sd652032874);
  localparam logic signed [Q_W-1:0] ONE_Q14 = 16'sd16384;

  localparam logic signed [Z_W-1:0] ATAN_Q30 [TABLE_LEN] = '{
    33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
    33'sd67021686, 33'sd33543515, 33'sd16775850, 33'sd8388437,
    33'sd4194282, 33'sd2097149, 33'sd1048575, 33'sd524287,
    33'sd262143, 33'sd131071, 33'sd65535, 33'sd32767,
    33'sd16383, 33'sd8191, 33'sd4095, 33'sd2047,
    33'sd1023, 33'sd511, 33'sd255, 33'sd127
  };

  typedef struct packed {
    logic signed [Z_W-1:0] z_yaw;
    logic signed [Z_W-1:0] z_pitch;
    logic signed [Z_W-1:0] z_roll;
    logic flip_yaw;
    logic flip_pitch;
    logic flip_roll;
  } e2q_item_t;

endpackage

>>> design/e2q_front.sv
module e2q_front import e2q_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [FIELD_W-1:0] yaw_angle,
  input  logic signed [FIELD_W-1:0] pitch_angle,
  input  logic signed [FIELD_W-1:0] roll_angle,
  output logic item_valid,
  input  logic item_ready,
  output e2q_item_t item
);

  logic fv;
  e2q_item_t item_next;

  // halve the angle in Q30 and fold into plus or minus pi/2
  function automatic logic [Z_W:0] reduce(input logic [FIELD_W-1:0] raw);
    logic signed [ANGLE_BITS-1:0] a;
    logic signed [WIDE_W-1:0] z;
    logic flip;
    a = raw[ANGLE_BITS-1:0];
    z = WIDE_W'(a) <<< (ANGLE_SHIFT);
    flip = 1'b0;
    if (z > HALF_PI_Q30) begin
      z = z - PI_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z = z + PI_Q30;
      flip = 1'b1;
    end
    return {flip, z[Z_W-1:0]};
  endfunction

  always_comb begin
    {item_next.flip_yaw, item_next.z_yaw} = reduce(yaw_angle);
    {item_next.flip_pitch, item_next.z_pitch} = reduce(pitch_angle);
    {item_next.flip_roll, item_next.z_roll} = reduce(roll_angle);
  end

  assign in_ready = !fv || item_ready;
  assign item_valid = fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

>>> design/e2q_queue.sv
module e2q_queue import e2q_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  e2q_item_t push_item,
  output logic pop_valid,
  input  logic pop_ready,
  output e2q_item_t pop_item
);

  e2q_item_t mem [2];
  logic wptr;
  logic rptr;
  logic [1:0] count;
  logic push;
  logic pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

>>> design/e2q_cordic.sv
module e2q_cordic import e2q_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic signed [Z_W-1:0] z_in,
  input  logic flip_in,
  output logic signed [X_W-1:0] cos_out,
  output logic signed [X_W-1:0] sin_out
);

  logic signed [X_W-1:0] xs [CORDIC_N+1];
  logic signed [X_W-1:0] ys [CORDIC_N+1];
  logic signed [Z_W-1:0] zs [CORDIC_N+1];
  logic fs [CORDIC_N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= GAIN_Q30;
      ys[0] <= '0;
      zs[0] <= z_in;
      fs[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_Q30[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_Q30[i];
        end
        fs[i+1] <= fs[i];
      end
    end
  end

  // undo the fold by pi
  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= fs[CORDIC_N] ? -xs[CORDIC_N] : xs[CORDIC_N];
      sin_out <= fs[CORDIC_N] ? -ys[CORDIC_N] : ys[CORDIC_N];
    end
  end

endmodule

>>> design/e2q_back.sv
module e2q_back import e2q_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  e2q_item_t item,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [Q_W-1:0] quat_w,
  output logic signed [Q_W-1:0] quat_x,
  output logic signed [Q_W-1:0] quat_y,
  output logic signed [Q_W-1:0] quat_z
);

  localparam int DEPTH = CORDIC_LAT + 5;

  logic en;
  logic [DEPTH-1:0] vld;
  logic signed [X_W-1:0] cy, sy, cp, sp, cr, sr;
  logic signed [P1_W-1:0] p_cc, p_ss, p_sc, p_cs;
  logic signed [X_W-1:0] cr1, sr1, cr2, sr2;
  logic signed [TR_W-1:0] t_cc, t_ss, t_sc, t_cs;
  logic signed [P3_W-1:0] m [8];
  logic signed [SUM_W-1:0] s_w, s_x, s_y, s_z;

  function automatic logic signed [TR_W-1:0] rnd30(input logic signed [P1_W-1:0] p);
    logic signed [P1_W-1:0] t;
    t = p + (P1_W'(1) <<< 29);
    return t[P1_W-1:30];
  endfunction

  function automatic logic signed [Q_W-1:0] to_q14(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-47:0] r;
    t = s + (SUM_W'(1) <<< 45);
    r = t[SUM_W-1:46];
    if (r > (SUM_W-46)'(ONE_Q14)) return ONE_Q14;
    if (r < -((SUM_W-46)'(ONE_Q14))) return -ONE_Q14;
    return r[Q_W-1:0];
  endfunction

  assign en = !out_valid || out_ready;
  assign item_ready = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], item_valid};
    end
  end

  e2q_cordic u_yaw (.clk, .en, .z_in(item.z_yaw), .flip_in(item.flip_yaw),
                    .cos_out(cy), .sin_out(sy));
  e2q_cordic u_pitch (.clk, .en, .z_in(item.z_pitch), .flip_in(item.flip_pitch),
                      .cos_out(cp), .sin_out(sp));
  e2q_cordic u_roll (.clk, .en, .z_in(item.z_roll), .flip_in(item.flip_roll),
                     .cos_out(cr), .sin_out(sr));

  always_ff @(posedge clk) begin
    if (en) begin
      p_cc <= cy * cp;
      p_ss <= sy * sp;
      p_sc <= sy * cp;
      p_cs <= cy * sp;
      cr1 <= cr;
      sr1 <= sr;
      t_cc <= rnd30(p_cc);
      t_ss <= rnd30(p_ss);
      t_sc <= rnd30(p_sc);
      t_cs <= rnd30(p_cs);
      cr2 <= cr1;
      sr2 <= sr1;
      m[0] <= t_cc * cr2;
      m[1] <= t_ss * sr2;
      m[2] <= t_cc * sr2;
      m[3] <= t_ss * cr2;
      m[4] <= t_sc * sr2;
      m[5] <= t_cs * cr2;
      m[6] <= t_sc * cr2;
      m[7] <= t_cs * sr2;
      s_w <= SUM_W'(m[0]) + SUM_W'(m[1]);
      s_x <= SUM_W'(m[2]) - SUM_W'(m[3]);
      s_y <= SUM_W'(m[4]) + SUM_W'(m[5]);
      s_z <= SUM_W'(m[6]) - SUM_W'(m[7]);
      quat_w <= to_q14(s_w);
      quat_x <= to_q14(s_x);
      quat_y <= to_q14(s_y);
      quat_z <= to_q14(s_z);
    end
  end

endmodule

>>> design/euler_to_quaternion_top.sv
// Throughput: one beat per cycle; the back pipeline advances whenever the output
// register is empty or being taken, and the CORDIC stages make up most of the pipeline.
// Reset: synchronous, active high; clears the valid flags, the queue pointers and count.
// Payload registers are not reset.
module euler_to_quaternion_top import e2q_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [FIELD_W-1:0] yaw_angle,
  input  logic signed [FIELD_W-1:0] pitch_angle,
  input  logic signed [FIELD_W-1:0] roll_angle,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [Q_W-1:0] quat_w,
  output logic signed [Q_W-1:0] quat_x,
  output logic signed [Q_W-1:0] quat_y,
  output logic signed [Q_W-1:0] quat_z
);

  // front: halve and fold each angle into the CORDIC's range
  logic f_valid, f_ready;
  e2q_item_t f_item;
  // queue: hold up to two beats so front and back stall apart
  logic b_valid, b_ready;
  e2q_item_t b_item;

  e2q_front u_front (
    .clk, .rst, .in_valid, .in_ready, .yaw_angle, .pitch_angle, .roll_angle,
    .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
  );

  e2q_queue u_queue (
    .clk, .rst,
    .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_item(b_item)
  );

  // back: three CORDICs, triple products, round and saturate
  e2q_back u_back (
    .clk, .rst, .item_valid(b_valid), .item_ready(b_ready), .item(b_item),
    .out_valid, .out_ready, .quat_w, .quat_x, .quat_y, .quat_z
  );

endmodule

>>> design/e2q_checker.sv
module e2q_checker import e2q_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic signed [Q_W-1:0] quat_w,
  input logic signed [Q_W-1:0] quat_x,
  input logic signed [Q_W-1:0] quat_y,
  input logic signed [Q_W-1:0] quat_z
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat visible after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(quat_w) && $stable(quat_x)
      && $stable(quat_y) && $stable(quat_z))
    else $error("output payload changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quat_w >= -ONE_Q14 && quat_w <= ONE_Q14
      && quat_x >= -ONE_Q14 && quat_x <= ONE_Q14
      && quat_y >= -ONE_Q14 && quat_y <= ONE_Q14
      && quat_z >= -ONE_Q14 && quat_z <= ONE_Q14)
    else $error("component outside plus or minus one");

endmodule

bind euler_to_quaternion_top e2q_checker u_e2q_checker (
  .clk, .rst, .out_valid, .out_ready, .quat_w, .quat_x, .quat_y, .quat_z
);

>>> bench/euler_to_quaternion_top_tb.sv
`timescale 1ns / 100ps

module euler_to_quaternion_top_tb;
  import e2q_pkg::*;

  localparam int N_RANDOM = 1330;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4 * (TRIG_STAGES + 9);

  // Angle constants in Q4.12 radians.
  localparam logic signed [15:0] A_MAX = 16'sh7fff;
  localparam logic signed [15:0] A_MIN = -16'sh8000;
  localparam logic signed [15:0] A_PI = 16'sd12868;
  localparam logic signed [15:0] A_HALFPI = 16'sd6434;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    bit has_quat;
    quat_t quat;
  } pose_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] yaw_angle = '0;
  logic signed [15:0] pitch_angle = '0;
  logic signed [15:0] roll_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;

  quat_t quat_due[$];
  int mismatches = 0;
  int cycles = 0;
  bit sending_done = 1'b0;
  pose_row_t poses[$];

  euler_to_quaternion_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .yaw_angle(yaw_angle), .pitch_angle(pitch_angle), .roll_angle(roll_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Floor shift on a 64-bit signed value.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Cosine and sine of the half angle in Q30, after the quadrant fold.
  task automatic half_cos_sin(input logic signed [15:0] ang, output longint c,
                              output longint s);
    longint atans[24];
    longint zz, xx, yy, dx, dy;
    logic signed [ANGLE_BITS-1:0] narrow;
    bit neg;
    atans = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
              16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
              131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
    narrow = ang[ANGLE_BITS-1:0];
    zz = longint'(narrow) * (64'sd1 <<< ANGLE_SHIFT);
    xx = 652032874;
    yy = 0;
    neg = 1'b0;
    if (zz > 64'sd1686629713) begin
      zz -= 64'sd3373259426;
      neg = 1'b1;
    end else if (zz < -64'sd1686629713) begin
      zz += 64'sd3373259426;
      neg = 1'b1;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = floor_shift(yy, i);
      dy = floor_shift(xx, i);
      if (zz >= 0) begin
        xx -= dx; yy += dy; zz -= atans[i];
      end else begin
        xx += dx; yy -= dy; zz += atans[i];
      end
    end
    c = neg ? -xx : xx;
    s = neg ? -yy : yy;
  endtask

  function automatic longint triple_q60(longint a, longint b, longint c);
    return floor_shift(a * b + (64'sd1 <<< 29), 30) * c;
  endfunction

  function automatic logic signed [15:0] round_q14(longint q60);
    longint r;
    r = floor_shift(q60 + (64'sd1 <<< 45), 46);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  task automatic predict_quat(input logic signed [15:0] yw, input logic signed [15:0] pt,
                              input logic signed [15:0] rl, output quat_t q);
    longint cy, sy, cp, sp, cr, sr;
    half_cos_sin(yw, cy, sy);
    half_cos_sin(pt, cp, sp);
    half_cos_sin(rl, cr, sr);
    q.w = round_q14(triple_q60(cy, cp, cr) + triple_q60(sy, sp, sr));
    q.x = round_q14(triple_q60(cy, cp, sr) - triple_q60(sy, sp, cr));
    q.y = round_q14(triple_q60(sy, cp, sr) + triple_q60(cy, sp, cr));
    q.z = round_q14(triple_q60(sy, cp, cr) - triple_q60(cy, sp, sr));
  endtask

  function automatic quat_t mk(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    return q;
  endfunction

  function automatic pose_row_t row(logic signed [15:0] yw, logic signed [15:0] pt,
                                    logic signed [15:0] rl, bit known, quat_t q);
    pose_row_t r;
    r.yaw = yw; r.pitch = pt; r.roll = rl; r.has_quat = known; r.quat = q;
    return r;
  endfunction

  // Random angle: half uniform, the rest near the fold points, the extremes and zero.
  function automatic logic signed [15:0] pick_angle();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return A_PI + 16'($urandom_range(0, 6) - 3);
      1: return -A_PI + 16'($urandom_range(0, 6) - 3);
      2: return A_MAX - 16'($urandom_range(0, 3));
      3: return A_MIN + 16'($urandom_range(0, 3));
      4: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  // Stimulus: directed table first, then random poses.
  initial begin : feed
    pose_row_t r;
    quat_t q;
    int gap;
    quat_t none;
    none = '0;
    // Identity, then single axes and all three axes at the ends of the angle range.
    poses.push_back(row(0, 0, 0, 1, mk(16384, 0, 0, 0)));
    poses.push_back(row(A_MAX, 0, 0, 0, none));
    poses.push_back(row(A_MIN, 0, 0, 0, none));
    poses.push_back(row(0, A_MAX, 0, 0, none));
    poses.push_back(row(0, A_MIN, 0, 0, none));
    poses.push_back(row(0, 0, A_MAX, 0, none));
    poses.push_back(row(0, 0, A_MIN, 0, none));
    poses.push_back(row(A_MAX, A_MAX, A_MAX, 0, none));
    poses.push_back(row(A_MIN, A_MIN, A_MIN, 0, none));
    poses.push_back(row(A_MAX, A_MIN, A_MAX, 0, none));
    // Half angle right at and just past the fold, then quarter turns and bit patterns.
    poses.push_back(row(A_PI, 0, 0, 0, none));
    poses.push_back(row(A_PI + 16'sd1, 0, 0, 0, none));
    poses.push_back(row(-A_PI, 0, 0, 0, none));
    poses.push_back(row(-A_PI - 16'sd1, 0, 0, 0, none));
    poses.push_back(row(0, A_PI + 16'sd1, -A_PI - 16'sd1, 0, none));
    poses.push_back(row(A_HALFPI, A_HALFPI, A_HALFPI, 0, none));
    poses.push_back(row(-A_HALFPI, A_HALFPI, -A_HALFPI, 0, none));
    poses.push_back(row(16'sd1, -16'sd1, 16'sd1, 0, none));
    poses.push_back(row(16'sh5555, 16'shaaaa, 16'sh5555, 0, none));
    poses.push_back(row(16'shaaaa, 16'sh5555, 16'shaaaa, 0, none));
    for (int i = 0; i < N_RANDOM; i++)
      poses.push_back(row(pick_angle(), pick_angle(), pick_angle(), 0, none));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (poses[i]) begin
      r = poses[i];
      // Runs of back-to-back beats are kept in by the zero draws.
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      // Drop valid only when the next beat is not immediately due.
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      yaw_angle <= r.yaw;
      pitch_angle <= r.pitch;
      roll_angle <= r.roll;
      if (r.has_quat) q = r.quat;
      else predict_quat(r.yaw, r.pitch, r.roll, q);
      quat_due.push_back(q);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stalls, with periods of constant readiness.
  initial begin : drain
    int stall;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (stall != 0) out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!rst) begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    quat_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {quat_w, quat_x, quat_y, quat_z};
      if (quat_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat w=%0d x=%0d y=%0d z=%0d",
                                       got.w, got.x, got.y, got.z);
      end else begin
        want = quat_due.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
        end
      end
    end
  end

  // Hold until everything is in and out, then allow the drain window.
  initial begin : finish_run
    wait (sending_done && quat_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && quat_due.size() == 0) $display("euler_to_quaternion_top_tb passed");
    else $display("euler_to_quaternion_top_tb failed");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("euler_to_quaternion_top_tb failed");
      $finish;
    end
  end

endmodule
